[rtl/gprc_pkg.sv]
`default_nettype none

package gprc_pkg;

	localparam int CNT_W = 17;
	localparam int OFF_W = 17;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [7:0] CH_OK = 8'h00;
	localparam logic [7:0] CH_ERR = 8'h01;
	localparam logic [7:0] PRIO_BIT = 8'h80;

	localparam logic [CNT_W-1:0] LEN_MIN = CNT_W'(3);
	localparam logic [CNT_W-1:0] LEN_CHOICE = CNT_W'(4);
	localparam logic [CNT_W-1:0] LEN_NORMAL_ERR = CNT_W'(5);
	localparam logic [CNT_W-1:0] LEN_BLOCK_HDR = CNT_W'(11);

	localparam logic [CNT_W-1:0] POS_SUBTYPE = CNT_W'(1);
	localparam logic [CNT_W-1:0] POS_INVOKE = CNT_W'(2);
	localparam logic [CNT_W-1:0] POS_CHOICE = CNT_W'(3);
	localparam logic [CNT_W-1:0] POS_BLKNUM_FIRST = CNT_W'(4);
	localparam logic [CNT_W-1:0] POS_BLKNUM_LAST = CNT_W'(7);
	localparam logic [CNT_W-1:0] POS_BLK_CHOICE = CNT_W'(8);
	localparam logic [CNT_W-1:0] POS_RAW_FIRST = CNT_W'(9);
	localparam logic [CNT_W-1:0] POS_RAW_LAST = CNT_W'(10);

	localparam logic [4:0] ERR_NONE = 5'd0;
	localparam logic [4:0] ERR_SHORT = 5'd1;
	localparam logic [4:0] ERR_NRM_NO_CHOICE = 5'd2;
	localparam logic [4:0] ERR_NRM_NO_DATA = 5'd3;
	localparam logic [4:0] ERR_NRM_ERR_LEN = 5'd4;
	localparam logic [4:0] ERR_NRM_BAD_CHOICE = 5'd5;
	localparam logic [4:0] ERR_BLK_SHORT = 5'd6;
	localparam logic [4:0] ERR_BLK_LEN = 5'd7;
	localparam logic [4:0] ERR_BLK_ERR_RAW = 5'd8;
	localparam logic [4:0] ERR_BLK_BAD_CHOICE = 5'd9;
	localparam logic [4:0] ERR_LST_NO_COUNT = 5'd10;
	localparam logic [4:0] ERR_LST_TRUNC = 5'd11;
	localparam logic [4:0] ERR_LST_NO_DATA = 5'd12;
	localparam logic [4:0] ERR_LST_NO_CODE = 5'd13;
	localparam logic [4:0] ERR_LST_BAD_CHOICE = 5'd14;
	localparam logic [4:0] ERR_LST_EXTRA = 5'd15;
	localparam logic [4:0] ERR_UNKNOWN = 5'd16;

	localparam logic [1:0] CFG_NORMAL = 2'd0;
	localparam logic [1:0] CFG_DATABLOCK = 2'd1;
	localparam logic [1:0] CFG_LIST = 2'd2;

	typedef enum logic [1:0] {
		VAR_NONE   = 2'd0,
		VAR_NORMAL = 2'd1,
		VAR_BLOCK  = 2'd2,
		VAR_LIST   = 2'd3
	} variant_t;

	typedef enum logic [3:0] {
		PH_CHOICE = 4'b0001,
		PH_DATA   = 4'b0010,
		PH_CODE   = 4'b0100,
		PH_DONE   = 4'b1000
	} list_phase_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} beat_t;

	typedef struct packed {
		logic             frame_ok;
		logic [4:0]       error_code;
		logic [OFF_W-1:0] error_offset;
		logic [7:0]       service_subtype;
		logic [7:0]       invoke_id;
		logic             high_priority;
		logic [7:0]       result_choice;
		logic             last_block;
		logic [31:0]      block_number;
		logic [7:0]       list_count;
		logic [OFF_W-1:0] frame_length;
	} result_t;

	typedef struct packed {
		logic [7:0] normal_code;
		logic [7:0] datablock_code;
		logic [7:0] list_code;
	} cfg_t;

	typedef struct packed {
		variant_t         variant;
		logic [CNT_W-1:0] len;
		logic [7:0]       subtype;
		logic [7:0]       invoke;
		logic [7:0]       byte3;
		logic [7:0]       choice;
		logic [31:0]      block_number;
		logic [15:0]      raw_length;
		logic [4:0]       first_error;
		logic [CNT_W-1:0] first_error_offset;
		list_phase_t      phase;
	} summary_t;

endpackage

`default_nettype wire

[rtl/gprc_front.sv]
`default_nettype none

module gprc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire gprc_pkg::cfg_t   cfg,
	input  wire logic             accept,
	input  wire gprc_pkg::beat_t  beat,
	output logic                  push,
	output gprc_pkg::summary_t    summary
);
	import gprc_pkg::*;

	logic [CNT_W-1:0] count_q, count_n;
	logic [7:0]       subtype_q, subtype_n;
	logic [7:0]       invoke_q, invoke_n;
	logic [7:0]       byte3_q, byte3_n;
	logic [7:0]       choice_q, choice_n;
	logic [31:0]      blknum_q, blknum_n;
	logic [15:0]      raw_q, raw_n;
	logic [7:0]       items_q, items_n;
	list_phase_t      phase_q, phase_n;
	logic [4:0]       ferr_q, ferr_n;
	logic [CNT_W-1:0] foff_q, foff_n;
	variant_t         variant;
	logic [7:0]       b;
	logic [CNT_W-1:0] p;

	assign b = beat.frame_byte;
	assign p = count_q;

	always_comb begin
		subtype_n = subtype_q;
		invoke_n = invoke_q;
		byte3_n = byte3_q;
		choice_n = choice_q;
		blknum_n = blknum_q;
		raw_n = raw_q;
		if (p == POS_SUBTYPE) begin
			subtype_n = b;
		end else if (p == POS_INVOKE) begin
			invoke_n = b;
		end else if (p == POS_CHOICE) begin
			byte3_n = b;
		end else if (p >= POS_BLKNUM_FIRST && p <= POS_BLKNUM_LAST) begin
			blknum_n = {blknum_q[23:0], b};
		end else if (p == POS_BLK_CHOICE) begin
			choice_n = b;
		end else if (p == POS_RAW_FIRST || p == POS_RAW_LAST) begin
			raw_n = {raw_q[7:0], b};
		end
	end

	// The variant is judged with the register values of this very beat.
	always_comb begin
		if (subtype_n == cfg.normal_code) begin
			variant = VAR_NORMAL;
		end else if (subtype_n == cfg.datablock_code) begin
			variant = VAR_BLOCK;
		end else if (subtype_n == cfg.list_code) begin
			variant = VAR_LIST;
		end else begin
			variant = VAR_NONE;
		end
	end

	always_comb begin
		items_n = items_q;
		phase_n = phase_q;
		ferr_n = ferr_q;
		foff_n = foff_q;
		if (variant == VAR_LIST && p == POS_CHOICE) begin
			items_n = b;
			phase_n = (b == 8'd0) ? PH_DONE : PH_CHOICE;
		end else if (variant == VAR_LIST && p >= POS_BLKNUM_FIRST && ferr_q == ERR_NONE) begin
			unique case (phase_q)
				PH_CHOICE: begin
					if (b == CH_OK) begin
						phase_n = PH_DATA;
					end else if (b == CH_ERR) begin
						phase_n = PH_CODE;
					end else begin
						ferr_n = ERR_LST_BAD_CHOICE;
						foff_n = p;
						phase_n = PH_DONE;
					end
				end
				PH_DATA, PH_CODE: begin
					items_n = items_q - 8'd1;
					phase_n = (items_n == 8'd0) ? PH_DONE : PH_CHOICE;
				end
				PH_DONE: begin
					ferr_n = ERR_LST_EXTRA;
					foff_n = p;
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
	end

	assign count_n = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);
	assign push = accept && beat.frame_end;

	always_comb begin
		summary.variant = variant;
		summary.len = count_n;
		summary.subtype = subtype_n;
		summary.invoke = invoke_n;
		summary.byte3 = byte3_n;
		summary.choice = choice_n;
		summary.block_number = blknum_n;
		summary.raw_length = raw_n;
		summary.first_error = ferr_n;
		summary.first_error_offset = foff_n;
		summary.phase = phase_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			subtype_q <= '0;
			invoke_q <= '0;
			byte3_q <= '0;
			choice_q <= '0;
			blknum_q <= '0;
			raw_q <= '0;
			items_q <= '0;
			phase_q <= PH_CHOICE;
			ferr_q <= ERR_NONE;
			foff_q <= '0;
		end else if (accept) begin
			if (beat.frame_end) begin
				count_q <= '0;
				subtype_q <= '0;
				invoke_q <= '0;
				byte3_q <= '0;
				choice_q <= '0;
				blknum_q <= '0;
				raw_q <= '0;
				items_q <= '0;
				phase_q <= PH_CHOICE;
				ferr_q <= ERR_NONE;
				foff_q <= '0;
			end else begin
				count_q <= count_n;
				subtype_q <= subtype_n;
				invoke_q <= invoke_n;
				byte3_q <= byte3_n;
				choice_q <= choice_n;
				blknum_q <= blknum_n;
				raw_q <= raw_n;
				items_q <= items_n;
				phase_q <= phase_n;
				ferr_q <= ferr_n;
				foff_q <= foff_n;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/gprc_queue.sv]
`default_nettype none

module gprc_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire gprc_pkg::summary_t  wdata,
	input  wire logic                pop,
	output logic                     full,
	output logic                     valid,
	output gprc_pkg::summary_t       rdata
);
	import gprc_pkg::*;

	summary_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/gprc_back.sv]
`default_nettype none

module gprc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	input  wire gprc_pkg::summary_t  q_data,
	output logic                     pop,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output gprc_pkg::result_t        result_data
);
	import gprc_pkg::*;

	result_t          r;
	logic [4:0]       code;
	logic [CNT_W-1:0] off;
	logic [CNT_W-1:0] blk_len;
	logic             out_valid_q;
	result_t          out_data_q;

	assign blk_len = LEN_BLOCK_HDR + CNT_W'(q_data.raw_length);

	always_comb begin
		r = '0;
		code = ERR_NONE;
		off = '0;
		if (q_data.len < LEN_MIN) begin
			code = ERR_SHORT;
		end else begin
			r.service_subtype = q_data.subtype;
			r.invoke_id = q_data.invoke;
			r.high_priority = (q_data.invoke & PRIO_BIT) != 8'd0;
			unique case (q_data.variant)
				VAR_NORMAL: begin
					if (q_data.len < LEN_CHOICE) begin
						code = ERR_NRM_NO_CHOICE;
						off = POS_CHOICE;
					end else begin
						r.result_choice = q_data.byte3;
						if (q_data.byte3 == CH_OK) begin
							if (q_data.len < LEN_NORMAL_ERR) begin
								code = ERR_NRM_NO_DATA;
								off = POS_BLKNUM_FIRST;
							end
						end else if (q_data.byte3 == CH_ERR) begin
							if (q_data.len != LEN_NORMAL_ERR) begin
								code = ERR_NRM_ERR_LEN;
								off = POS_BLKNUM_FIRST;
							end
						end else begin
							code = ERR_NRM_BAD_CHOICE;
							off = POS_CHOICE;
						end
					end
				end
				VAR_BLOCK: begin
					if (q_data.len < LEN_BLOCK_HDR) begin
						code = ERR_BLK_SHORT;
						off = POS_CHOICE;
					end else begin
						r.result_choice = q_data.choice;
						r.last_block = (q_data.byte3 == CH_ERR);
						r.block_number = q_data.block_number;
						if (q_data.choice == CH_OK) begin
							if (q_data.len != blk_len) begin
								code = ERR_BLK_LEN;
								off = POS_RAW_FIRST;
							end
						end else if (q_data.choice == CH_ERR) begin
							if (q_data.raw_length != 16'd0) begin
								code = ERR_BLK_ERR_RAW;
								off = POS_RAW_FIRST;
							end
						end else begin
							code = ERR_BLK_BAD_CHOICE;
							off = POS_BLK_CHOICE;
						end
					end
				end
				VAR_LIST: begin
					if (q_data.len < LEN_CHOICE) begin
						code = ERR_LST_NO_COUNT;
						off = POS_CHOICE;
					end else begin
						r.list_count = q_data.byte3;
						if (q_data.first_error != ERR_NONE) begin
							code = q_data.first_error;
							off = q_data.first_error_offset;
						end else if (q_data.phase == PH_CHOICE) begin
							code = ERR_LST_TRUNC;
							off = q_data.len;
						end else if (q_data.phase == PH_DATA) begin
							code = ERR_LST_NO_DATA;
							off = q_data.len;
						end else if (q_data.phase == PH_CODE) begin
							code = ERR_LST_NO_CODE;
							off = q_data.len;
						end
					end
				end
				default: begin
					code = ERR_UNKNOWN;
					off = POS_SUBTYPE;
				end
			endcase
		end
		r.frame_ok = (code == ERR_NONE);
		r.error_code = code;
		r.error_offset = OFF_W'(off);
		r.frame_length = OFF_W'(q_data.len);
	end

	assign pop = q_valid && (!out_valid_q || !result_stall);
	assign result_valid = out_valid_q;
	assign result_data = out_data_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[rtl/get_response_frame_checker.sv]
// GET-Response frame checker. Frame bytes enter one beat per clock on the byte
// channel while byte_stall is low, the last byte of a frame marked by frame_end,
// and every byte is taken by the front end, which counts bytes, latches the
// header and walks the result list. A frame-end beat hands a frame summary to a
// two-entry queue, so byte_stall rises only when that queue is full; the back
// end checks the summary and places one result in an output register, which
// holds it while the output side is stalled. Subtype codes are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while no frame
// is in flight, and the block itself does not enforce this.

`default_nettype none

module get_response_frame_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [7:0]          cfg_data,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire gprc_pkg::beat_t     byte_data,
	output logic                     result_valid,
	input  wire logic                result_stall,
	output gprc_pkg::result_t        result_data
);
	import gprc_pkg::*;

	cfg_t     cfg_q;
	logic     accept;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_valid;
	summary_t push_data;
	summary_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal_code <= 8'd1;
			cfg_q.datablock_code <= 8'd2;
			cfg_q.list_code <= 8'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NORMAL: cfg_q.normal_code <= cfg_data;
				CFG_DATABLOCK: cfg_q.datablock_code <= cfg_data;
				CFG_LIST: cfg_q.list_code <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign byte_stall = q_full;
	assign accept = byte_valid && !q_full;

	gprc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.accept  (accept),
		.beat    (byte_data),
		.push    (push),
		.summary (push_data)
	);

	gprc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.full   (q_full),
		.valid  (q_valid),
		.rdata  (q_data)
	);

	gprc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

	a_ok_offset: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.frame_ok |-> result_data.error_offset == '0)
		else $error("passing frame carries an error offset");

	a_len_short: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.error_code != ERR_SHORT |->
		result_data.frame_length >= OFF_W'(LEN_MIN))
		else $error("short frame not reported as too short");

	a_pop_fills: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> result_valid)
		else $error("queue entry taken without a result appearing");

endmodule

`default_nettype wire

[tb/get_response_frame_checker_tb.sv]
`default_nettype none

module get_response_frame_checker_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import gprc_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int RESET_CYCLES = 12;
	localparam int QUIET_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_PRINTED = 40;

	typedef logic [7:0] byte_q_t[$];

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;
	logic byte_valid;
	logic byte_stall;
	beat_t byte_data;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result_data;

	get_response_frame_checker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Subtype codes as the block currently holds them.
	logic [7:0] code_normal = 8'h01;
	logic [7:0] code_block = 8'h02;
	logic [7:0] code_list = 8'h03;

	// Frame state of the checker as predicted beat by beat.
	logic [CNT_W-1:0] pos_count = '0;
	logic [7:0] hdr_subtype = '0;
	logic [7:0] hdr_invoke = '0;
	logic [7:0] hdr_byte3 = '0;
	logic [7:0] blk_choice = '0;
	logic [31:0] blk_index = '0;
	logic [15:0] blk_raw_len = '0;
	logic [7:0] items_pending = '0;
	list_phase_t walk_phase = PH_CHOICE;
	logic [4:0] err_first = ERR_NONE;
	logic [CNT_W-1:0] err_first_off = '0;

	result_t expected_results[$];
	result_t oldest_expected;

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned bytes_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned results_checked = 0;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
				results_checked, name, got, want));
	endtask

	task automatic compare_result(input result_t got, input result_t want);
		check_field("frame_ok", 32'(got.frame_ok), 32'(want.frame_ok));
		check_field("error_code", 32'(got.error_code), 32'(want.error_code));
		check_field("error_offset", 32'(got.error_offset), 32'(want.error_offset));
		check_field("service_subtype", 32'(got.service_subtype),
			32'(want.service_subtype));
		check_field("invoke_id", 32'(got.invoke_id), 32'(want.invoke_id));
		check_field("high_priority", 32'(got.high_priority), 32'(want.high_priority));
		check_field("result_choice", 32'(got.result_choice), 32'(want.result_choice));
		check_field("last_block", 32'(got.last_block), 32'(want.last_block));
		check_field("block_number", got.block_number, want.block_number);
		check_field("list_count", 32'(got.list_count), 32'(want.list_count));
		check_field("frame_length", 32'(got.frame_length), 32'(want.frame_length));
	endtask

	function automatic variant_t variant_of_subtype(input logic [7:0] s);
		if (s == code_normal)
			return VAR_NORMAL;
		if (s == code_block)
			return VAR_BLOCK;
		if (s == code_list)
			return VAR_LIST;
		return VAR_NONE;
	endfunction

	function automatic void note_error(input logic [4:0] code, input logic [CNT_W-1:0] off);
		if (err_first == ERR_NONE) begin
			err_first = code;
			err_first_off = off;
		end
	endfunction

	function automatic void clear_frame_state();
		pos_count = '0;
		hdr_subtype = '0;
		hdr_invoke = '0;
		hdr_byte3 = '0;
		blk_choice = '0;
		blk_index = '0;
		blk_raw_len = '0;
		items_pending = '0;
		walk_phase = PH_CHOICE;
		err_first = ERR_NONE;
		err_first_off = '0;
	endfunction

	// Advances the predicted frame state by one accepted beat and, on the
	// frame-end beat, queues the result that the checker must report.
	function automatic void absorb_byte(input logic [7:0] value, input logic last);
		logic [CNT_W-1:0] p;
		logic [CNT_W-1:0] n;
		variant_t v;
		logic [4:0] code;
		logic [CNT_W-1:0] off;
		result_t r;
		p = pos_count;
		if (p == POS_SUBTYPE)
			hdr_subtype = value;
		else if (p == POS_INVOKE)
			hdr_invoke = value;
		else if (p == POS_CHOICE)
			hdr_byte3 = value;
		else if (p >= POS_BLKNUM_FIRST && p <= POS_BLKNUM_LAST)
			blk_index = {blk_index[23:0], value};
		else if (p == POS_BLK_CHOICE)
			blk_choice = value;
		else if (p >= POS_RAW_FIRST && p <= POS_RAW_LAST)
			blk_raw_len = {blk_raw_len[7:0], value};

		v = variant_of_subtype(hdr_subtype);
		if (v == VAR_LIST && p == POS_CHOICE) begin
			items_pending = value;
			walk_phase = (value == 8'h00) ? PH_DONE : PH_CHOICE;
		end else if (v == VAR_LIST && p >= POS_BLKNUM_FIRST && err_first == ERR_NONE) begin
			case (walk_phase)
				PH_CHOICE: begin
					if (value == CH_OK)
						walk_phase = PH_DATA;
					else if (value == CH_ERR)
						walk_phase = PH_CODE;
					else begin
						note_error(ERR_LST_BAD_CHOICE, p);
						walk_phase = PH_DONE;
					end
				end
				PH_DATA, PH_CODE: begin
					items_pending = items_pending - 8'd1;
					walk_phase = (items_pending == 8'h00) ? PH_DONE : PH_CHOICE;
				end
				default: note_error(ERR_LST_EXTRA, p);
			endcase
		end

		if (pos_count != CNT_MAX)
			pos_count = pos_count + CNT_W'(1);
		if (!last)
			return;

		frames_sent++;
		n = pos_count;
		r = '0;
		code = ERR_NONE;
		off = '0;
		if (n < LEN_MIN) begin
			code = ERR_SHORT;
		end else begin
			r.service_subtype = hdr_subtype;
			r.invoke_id = hdr_invoke;
			r.high_priority = (hdr_invoke & PRIO_BIT) != 8'h00;
			case (v)
				VAR_NORMAL: begin
					if (n < LEN_CHOICE) begin
						code = ERR_NRM_NO_CHOICE;
						off = POS_CHOICE;
					end else begin
						r.result_choice = hdr_byte3;
						if (hdr_byte3 == CH_OK) begin
							if (n < LEN_NORMAL_ERR) begin
								code = ERR_NRM_NO_DATA;
								off = POS_BLKNUM_FIRST;
							end
						end else if (hdr_byte3 == CH_ERR) begin
							if (n != LEN_NORMAL_ERR) begin
								code = ERR_NRM_ERR_LEN;
								off = POS_BLKNUM_FIRST;
							end
						end else begin
							code = ERR_NRM_BAD_CHOICE;
							off = POS_CHOICE;
						end
					end
				end
				VAR_BLOCK: begin
					if (n < LEN_BLOCK_HDR) begin
						code = ERR_BLK_SHORT;
						off = POS_CHOICE;
					end else begin
						r.result_choice = blk_choice;
						r.last_block = (hdr_byte3 == CH_ERR);
						r.block_number = blk_index;
						if (blk_choice == CH_OK) begin
							if (n != LEN_BLOCK_HDR + CNT_W'(blk_raw_len)) begin
								code = ERR_BLK_LEN;
								off = POS_RAW_FIRST;
							end
						end else if (blk_choice == CH_ERR) begin
							if (blk_raw_len != 16'h0000) begin
								code = ERR_BLK_ERR_RAW;
								off = POS_RAW_FIRST;
							end
						end else begin
							code = ERR_BLK_BAD_CHOICE;
							off = POS_BLK_CHOICE;
						end
					end
				end
				VAR_LIST: begin
					if (n < LEN_CHOICE) begin
						code = ERR_LST_NO_COUNT;
						off = POS_CHOICE;
					end else begin
						r.list_count = hdr_byte3;
						if (err_first != ERR_NONE) begin
							code = err_first;
							off = err_first_off;
						end else if (walk_phase == PH_CHOICE) begin
							code = ERR_LST_TRUNC;
							off = n;
						end else if (walk_phase == PH_DATA) begin
							code = ERR_LST_NO_DATA;
							off = n;
						end else if (walk_phase == PH_CODE) begin
							code = ERR_LST_NO_CODE;
							off = n;
						end
					end
				end
				default: begin
					code = ERR_UNKNOWN;
					off = POS_SUBTYPE;
				end
			endcase
		end
		r.frame_ok = (code == ERR_NONE);
		r.error_code = code;
		r.error_offset = off;
		r.frame_length = n;
		expected_results = {expected_results, r};
		clear_frame_state();
	endfunction

	task automatic send_beat(input logic [7:0] value, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= '{frame_byte: value, frame_end: last};
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		bytes_sent++;
		absorb_byte(value, last);
	endtask

	task automatic send_frame(input byte_q_t f);
		foreach (f[i])
			send_beat(f[i], i == f.size() - 1);
	endtask

	// The sender holds off until every result has come, then lets the back end settle.
	task automatic wait_for_results();
		byte_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_code(input logic [1:0] index, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			CFG_NORMAL: code_normal = value;
			CFG_DATABLOCK: code_block = value;
			CFG_LIST: code_list = value;
			default: ;
		endcase
	endtask

	task automatic set_codes(input logic [7:0] normal, input logic [7:0] block,
			input logic [7:0] list);
		write_code(CFG_NORMAL, normal);
		write_code(CFG_DATABLOCK, block);
		write_code(CFG_LIST, list);
	endtask

	// Mostly well-formed frames of each variant with random content; the rest
	// is noise or frames that are cut short, padded or corrupted.
	function automatic byte_q_t random_frame();
		byte_q_t f;
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(99);
		f = {8'($urandom)};
		if (pick < 25) begin
			f = {f, code_normal};
			f = {f, 8'($urandom)};
			if ($urandom_range(1) == 0) begin
				f = {f, CH_OK};
				repeat ($urandom_range(1, 6)) f = {f, 8'($urandom)};
			end else begin
				f = {f, CH_ERR};
				f = {f, 8'($urandom)};
			end
		end else if (pick < 50) begin
			f = {f, code_block};
			f = {f, 8'($urandom)};
			f = {f, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1))};
			repeat (4) f = {f, 8'($urandom)};
			if ($urandom_range(3) == 0) begin
				f = {f, CH_ERR, 8'h00, 8'h00};
				repeat ($urandom_range(0, 2)) f = {f, 8'($urandom)};
			end else begin
				n = $urandom_range(0, 6);
				f = {f, CH_OK, 8'h00, 8'(n)};
				repeat (n) f = {f, 8'($urandom)};
			end
		end else if (pick < 80) begin
			n = $urandom_range(0, 5);
			f = {f, code_list};
			f = {f, 8'($urandom)};
			f = {f, 8'(n)};
			repeat (n) begin
				f = {f, ($urandom_range(1) == 0) ? CH_OK : CH_ERR};
				f = {f, 8'($urandom)};
			end
		end else begin
			repeat ($urandom_range(1, 14)) f = {f, 8'($urandom)};
			if (f.size() > 1 && $urandom_range(1) == 0) begin
				n = $urandom_range(2);
				f[1] = (n == 0) ? code_normal : (n == 1) ? code_block : code_list;
			end
		end
		if (pick < 80 && $urandom_range(3) == 0) begin
			case ($urandom_range(2))
				0: begin
					n = $urandom_range(1, f.size());
					while (f.size() > n)
						void'(f.pop_back());
				end
				1: repeat ($urandom_range(1, 3)) f = {f, 8'($urandom)};
				default: f[$urandom_range(f.size() - 1)] = 8'($urandom);
			endcase
		end
		return f;
	endfunction

	task automatic test_short_and_unknown();
		byte_q_t f;
		f = {8'hFF};
		send_frame(f);
		f = {8'h00, code_normal};
		send_frame(f);
		f = {8'h5A, 8'h09, 8'h80};
		send_frame(f);
		wait_for_results();
	endtask

	task automatic test_normal_variant();
		byte_q_t f;
		f = {8'h00, code_normal, 8'h05};
		send_frame(f);
		f = {8'h00, code_normal, 8'h05, CH_OK};
		send_frame(f);
		f = {8'h00, code_normal, 8'h85, CH_OK, 8'h07};
		send_frame(f);
		f = {8'h00, code_normal, 8'h05, CH_ERR, 8'h09, 8'h09};
		send_frame(f);
		f = {8'h00, code_normal, 8'h05, 8'h07};
		send_frame(f);
		wait_for_results();
	endtask

	task automatic test_block_variant();
		byte_q_t f;
		f = {8'h00, code_block, 8'h81, CH_ERR, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
			CH_OK, 8'h00, 8'h02, 8'hAA, 8'hBB};
		send_frame(f);
		f = {8'h00, code_block, 8'h01, 8'h00, 8'h12, 8'h34};
		send_frame(f);
		f = {8'h00, code_block, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
			CH_OK, 8'h00, 8'h02, 8'hAA};
		send_frame(f);
		f = {8'h00, code_block, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
			CH_ERR, 8'h00, 8'h03};
		send_frame(f);
		f = {8'h00, code_block, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
			8'h05, 8'h00, 8'h00};
		send_frame(f);
		wait_for_results();
	endtask

	task automatic test_list_variant();
		byte_q_t f;
		f = {8'h00, code_list, 8'h01};
		send_frame(f);
		f = {8'h00, code_list, 8'h01, 8'h02, CH_OK, 8'h11, CH_ERR, 8'h22};
		send_frame(f);
		f = {8'h00, code_list, 8'h01, 8'h02, CH_OK};
		send_frame(f);
		f = {8'h00, code_list, 8'h01, 8'h02, CH_OK, 8'h05};
		send_frame(f);
		f = {8'h00, code_list, 8'h01, 8'h01, CH_ERR};
		send_frame(f);
		f = {8'h00, code_list, 8'h01, 8'h01, 8'h07, CH_OK};
		send_frame(f);
		f = {8'h00, code_list, 8'h01, 8'h00, 8'h09, 8'h0A};
		send_frame(f);
		f = {8'h00, code_list, 8'h01, 8'h00};
		send_frame(f);
		wait_for_results();
	endtask

	task automatic test_code_extremes();
		byte_q_t f;
		set_codes(8'h00, 8'hFF, 8'h80);
		f = {8'h00, 8'h00, 8'hFF, CH_ERR, 8'h0B};
		send_frame(f);
		f = {8'h00, 8'hFF, 8'h7F, CH_ERR, 8'h00, 8'h00, 8'h00, 8'h2A,
			CH_ERR, 8'h00, 8'h00};
		send_frame(f);
		f = {8'h00, 8'h80, 8'h00, 8'h01, CH_OK, 8'h99};
		send_frame(f);
		f = {8'h00, 8'h01, 8'h00};
		send_frame(f);
		wait_for_results();
	endtask

	task automatic test_overlapping_codes();
		byte_q_t f;
		set_codes(8'h42, 8'h42, 8'h42);
		f = {8'h00, 8'h42, 8'h01, CH_OK, 8'h55};
		send_frame(f);
		wait_for_results();
		set_codes(8'h10, 8'h42, 8'h42);
		f = {8'h00, 8'h42, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			CH_OK, 8'h00, 8'h00};
		send_frame(f);
		wait_for_results();
	endtask

	task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned budget);
		int unsigned start;
		byte_q_t f;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			f = random_frame();
			send_frame(f);
			if ($urandom_range(7) == 0)
				wait_for_results();
		end
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		set_codes(8'h01, 8'h02, 8'h03);
		run_random_phase(0, 0, 85);
		set_codes(8'h00, 8'hFF, 8'h80);
		run_random_phase(73, 0, 85);
		set_codes(8'hA5, 8'hA5, 8'h3C);
		run_random_phase(0, 73, 85);
		set_codes(8'h11, 8'h7E, 8'h7E);
		run_random_phase(37, 37, 85);
	endtask

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < receiver_stall_pct);
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with no frame pending, frame_length %0d",
					result_data.frame_length));
			end else begin
				oldest_expected = expected_results.pop_front();
				compare_result(result_data, oldest_expected);
			end
			results_checked++;
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no beat moved for %0d cycles", quiet_cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_NORMAL;
		cfg_data <= 8'h00;
		byte_valid <= 1'b0;
		byte_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		test_short_and_unknown();
		test_normal_variant();
		test_block_variant();
		test_list_variant();
		test_code_extremes();
		test_overlapping_codes();
		test_random_traffic();

		wait_for_results();
		$display("Checked %0d frame results from %0d frames and %0d bytes.",
			results_checked, frames_sent, bytes_sent);
		$display("Covered all variants and error rules, code extremes, overlapping codes and four pacing modes; %0d mismatches.",
			error_count);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/gprc_pkg.sv
rtl/gprc_front.sv
rtl/gprc_queue.sv
rtl/gprc_back.sv
rtl/get_response_frame_checker.sv
tb/get_response_frame_checker_tb.sv
